### design/msne_pkg.sv
// msne_pkg: shared types and constants for the monotonic stack next element block
// no dependencies; imported by every module of the block
package msne_pkg;

  localparam int VALUE_W            = 32;
  localparam int INDEX_W            = 16;
  localparam int POS_MAX_W          = 32;
  localparam int STACK_DEPTH_DEF    = 32;
  localparam int POSITION_BITS_DEF  = 16;
  localparam int APB_ADDR_W         = 3;
  localparam int APB_DATA_W         = 32;

  // register index of search_mode, taken from paddr[2]
  localparam logic REG_SEARCH_MODE  = 1'b0;

  localparam logic MODE_GREATER     = 1'b0;
  localparam logic MODE_SMALLER     = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        element_index;
    logic signed [VALUE_W-1:0] next_value;
    logic                      found;
    logic                      overflow;
    logic                      last_of_run;
  } out_item_t;

endpackage

### design/msne_queue.sv
// msne_queue: two-entry queue between the front and the back
// depends on msne_pkg for the default of DATA_W; width set by DATA_W
module msne_queue import msne_pkg::*; #(
  parameter int DATA_W = VALUE_W + 1 + POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  input  logic              pop_ready
);

  logic [DATA_W-1:0] entry_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/msne_front.sv
// msne_front: accepts input transactions and stamps each with its sequence position
// depends on msne_pkg; feeds msne_queue
module msne_front import msne_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  in_item_t                               in_item,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [POSITION_BITS+VALUE_W:0]         q_push_data
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_push_data = {pos_r, in_item.end_of_sequence, in_item.sample_value};

  // numbering restarts after the element that ends a sequence
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = in_item.end_of_sequence ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### design/msne_back.sv
// msne_back: stack engine; pops resolved entries, evicts when full, pushes, flushes
// depends on msne_pkg; takes jobs from msne_queue and drives the output register
module msne_back import msne_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           search_mode,
  input  logic                           q_valid,
  input  logic [POSITION_BITS+VALUE_W:0] q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output out_item_t                      out_item
);

  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_READ   = 9'b000000010,
    ST_CMP    = 9'b000000100,
    ST_FULL   = 9'b000001000,
    ST_EVICT  = 9'b000010000,
    ST_PUSH   = 9'b000100000,
    ST_FLREAD = 9'b001000000,
    ST_FLEMIT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  // ring index: sum is below twice the depth, so one compare and subtract
  function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(STACK_DEPTH)) ? s - SUM_W'(STACK_DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [PTR_W-1:0]          base_r, base_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      last_r, last_nxt;
  logic [POSITION_BITS-1:0]  pos_r, pos_nxt;

  logic signed [VALUE_W-1:0] stack_val_r [STACK_DEPTH];
  logic [POSITION_BITS-1:0]  stack_pos_r [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rd_val_r;
  logic [POSITION_BITS-1:0]  rd_pos_r;

  logic                      held_valid_r, held_valid_nxt;
  out_item_t                 held_r, held_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_r, out_nxt;

  logic                      rd_en, wr_en;
  logic [PTR_W-1:0]          rd_addr, wr_addr;
  logic [PTR_W-1:0]          top_addr;
  logic                      out_free, can_emit, hit;
  logic                      emit_en, out_load;
  out_item_t                 emit_item, out_load_item;
  logic [POS_MAX_W-1:0]      rd_pos_ext;

  assign top_addr   = wrap_idx(SUM_W'(base_r) + SUM_W'(count_r) - SUM_W'(1));
  assign out_free   = !out_valid_r || !out_stall;
  assign can_emit   = !held_valid_r || out_free;
  assign rd_pos_ext = POS_MAX_W'(rd_pos_r);
  assign hit        = (search_mode == MODE_SMALLER) ? (val_r < rd_val_r) : (rd_val_r < val_r);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    count_nxt      = count_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = top_addr;
    wr_en          = 1'b0;
    wr_addr        = wrap_idx(SUM_W'(base_r) + SUM_W'(count_r));
    emit_en        = 1'b0;
    emit_item      = '0;
    emit_item.element_index = rd_pos_ext[INDEX_W-1:0];
    out_load       = 1'b0;
    out_load_item  = held_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          val_nxt   = q_data[VALUE_W-1:0];
          last_nxt  = q_data[VALUE_W];
          pos_nxt   = q_data[POSITION_BITS+VALUE_W:VALUE_W+1];
          state_nxt = (count_r != '0) ? ST_READ : ST_FULL;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!hit) begin
          state_nxt = ST_FULL;
        end else if (can_emit) begin
          emit_en              = 1'b1;
          emit_item.next_value = val_r;
          emit_item.found      = 1'b1;
          count_nxt            = count_r - 1'b1;
          state_nxt            = (count_r != CNT_W'(1)) ? ST_READ : ST_FULL;
        end
      end
      ST_FULL: begin
        // oldest entry goes out when no room is left for the push
        if (count_r == CNT_W'(STACK_DEPTH)) begin
          rd_en     = 1'b1;
          rd_addr   = base_r;
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_EVICT: begin
        if (can_emit) begin
          emit_en            = 1'b1;
          emit_item.overflow = 1'b1;
          base_nxt           = wrap_idx(SUM_W'(base_r) + SUM_W'(1));
          count_nxt          = count_r - 1'b1;
          state_nxt          = ST_PUSH;
        end
      end
      ST_PUSH: begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = last_r ? ST_FLREAD : ST_DONE;
      end
      ST_FLREAD: begin
        rd_en     = 1'b1;
        state_nxt = ST_FLEMIT;
      end
      ST_FLEMIT: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = (count_r != CNT_W'(1)) ? ST_FLREAD : ST_DONE;
        end
      end
      ST_DONE: begin
        // the held result is the last one of this transaction
        if (!held_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load                  = 1'b1;
          out_load_item.last_of_run = 1'b1;
          held_valid_nxt            = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // one result is held back until it is known whether another follows
    if (emit_en) begin
      if (held_valid_r) begin
        out_load                  = 1'b1;
        out_load_item.last_of_run = 1'b0;
      end
      held_nxt       = emit_item;
      held_valid_nxt = 1'b1;
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_nxt       = out_load ? out_load_item : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= '0;
      count_r      <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      count_r      <= count_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_val_r[wr_addr] <= val_r;
      stack_pos_r[wr_addr] <= pos_r;
    end
    if (rd_en) begin
      rd_val_r <= stack_val_r[rd_addr];
      rd_pos_r <= stack_pos_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### design/monotonic_stack_next_element.sv
// Next greater / next smaller element finder over a stream of signed 32-bit values.
// Input channel (in_valid, in_stall, in_item): one sequence element per transaction;
//   end_of_sequence marks the last element, which flushes every pending entry as not
//   found and restarts position numbering at zero.
// Output channel (out_valid, out_stall, out_item): zero or more results per input,
//   in order pops, eviction, flush; last_of_run marks the final result of an input.
// APB port: register 0 (byte address 0) holds search_mode, 0 greater, 1 smaller.
// Stack engine: each stack entry it examines or flushes takes a memory read, then a
//   compare or emit, on the engine's single memory read port. A two-entry queue in
//   front lets inputs be taken while work goes on.
// Each result of an input enters the output register only once the engine knows
//   whether another result follows it.
// Reset (synchronous, rst_n low) empties the stack and queue, zeroes the position
//   counter and clears search_mode. When out_stall is high the output holds, the
//   engine halts at its next result and the input side stalls once the queue fills.
module monotonic_stack_next_element import msne_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int JOB_W = POSITION_BITS + VALUE_W + 1;

  logic             search_mode_r, search_mode_nxt;
  logic             cfg_wr;
  logic             q_full, q_push, q_valid, q_pop;
  logic [JOB_W-1:0] q_push_data, q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEARCH_MODE);
  assign prdata = (paddr[2] == REG_SEARCH_MODE) ?
                  {{(APB_DATA_W-1){1'b0}}, search_mode_r} : '0;

  always_comb begin
    search_mode_nxt = cfg_wr ? pwdata[0] : search_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r <= MODE_GREATER;
    end else begin
      search_mode_r <= search_mode_nxt;
    end
  end

  msne_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  msne_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_pop)
  );

  msne_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .search_mode (search_mode_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

### design/msne_checker.sv
// msne_checker: port-level assertions for the next element finder, bound to the top level
// depends on msne_pkg and monotonic_stack_next_element
module msne_checker import msne_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.overflow |-> !out_item.found)
    else $error("evicted entry reported as found");

  a_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.next_value == '0)
    else $error("not found result carries a value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind monotonic_stack_next_element msne_checker u_msne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### tb/sv/tb_monotonic_stack_next_element.sv
// tb_monotonic_stack_next_element: self-checking testbench for the next greater / smaller
// element finder; predicts every result from its own stack model and checks each field
// depends on msne_pkg and monotonic_stack_next_element
`timescale 1ns / 100ps

module tb_monotonic_stack_next_element;
  import msne_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PCT       = 12;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 200;
  localparam int PHASE_ITEMS    = 40;

  localparam logic [APB_ADDR_W-1:0] ADDR_MODE   = {REG_SEARCH_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'b100;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // stack model
  logic signed [VALUE_W-1:0] pend_val [STACK_DEPTH_DEF];
  logic [INDEX_W-1:0]        pend_pos [STACK_DEPTH_DEF];
  int                        pend_cnt = 0;
  logic [INDEX_W-1:0]        next_pos = '0;
  logic                      cur_mode = MODE_GREATER;

  out_item_t expected_results[$];
  int        error_count = 0;
  int        stuck_cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;

  monotonic_stack_next_element i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void note_error();
    error_count++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      note_error();
      if (error_count <= MAX_REPORTS) begin
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    end
  endfunction

  // pops, then eviction, then flush, all for one accepted transaction
  function automatic void resolve_sample(in_item_t it);
    logic signed [VALUE_W-1:0] v;
    logic [INDEX_W-1:0]        pos;
    out_item_t                 res[$];
    bit                        hit;
    v   = it.sample_value;
    pos = next_pos;
    while (pend_cnt > 0) begin
      if (cur_mode == MODE_SMALLER) begin
        hit = v < pend_val[pend_cnt-1];
      end else begin
        hit = pend_val[pend_cnt-1] < v;
      end
      if (!hit) break;
      res.push_back('{pend_pos[pend_cnt-1], v, 1'b1, 1'b0, 1'b0});
      pend_cnt--;
    end
    if (pend_cnt >= STACK_DEPTH_DEF) begin
      res.push_back('{pend_pos[0], '0, 1'b0, 1'b1, 1'b0});
      for (int i = 1; i < STACK_DEPTH_DEF; i++) begin
        pend_val[i-1] = pend_val[i];
        pend_pos[i-1] = pend_pos[i];
      end
      pend_cnt = STACK_DEPTH_DEF - 1;
    end
    pend_val[pend_cnt] = v;
    pend_pos[pend_cnt] = pos;
    pend_cnt++;
    if (it.end_of_sequence) begin
      while (pend_cnt > 0) begin
        res.push_back('{pend_pos[pend_cnt-1], '0, 1'b0, 1'b0, 1'b0});
        pend_cnt--;
      end
      next_pos = '0;
    end else begin
      next_pos = pos + 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  // sample both channels at the rising edge, watchdog on lack of progress
  always @(posedge clk) begin : monitor
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        resolve_sample(in_item);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          note_error();
          if (error_count <= MAX_REPORTS) begin
            $error("unexpected result: element_index %0h", out_item.element_index);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("element_index", 32'(want.element_index), 32'(out_item.element_index));
          check_field("next_value", want.next_value, out_item.next_value);
          check_field("found", 32'(want.found), 32'(out_item.found));
          check_field("overflow", 32'(want.overflow), 32'(out_item.overflow));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_item.last_of_run));
        end
      end
      if (psel && penable && pready) moved = 1'b1;
    end
    if (moved || !rst_n) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid left high
  task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic eos);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= '{sample_value: v, end_of_sequence: eos};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // block is idle once every result is in and items without results have drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr[2] == REG_SEARCH_MODE) cur_mode = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_mode_readback();
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, ADDR_MODE, '0, rdata);
    if (rdata !== {{(APB_DATA_W-1){1'b0}}, cur_mode}) begin
      note_error();
      $error("search_mode readback: expected %0h, got %0h", cur_mode, rdata);
    end
  endtask

  // upper data bits are noise, only bit 0 lands in the register
  task automatic program_mode(input logic mode);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b1, ADDR_MODE, ($urandom & ~32'd1) | 32'(mode), rdata);
    check_mode_readback();
  endtask

  task automatic test_register_access();
    logic [APB_DATA_W-1:0] rdata;
    check_mode_readback();
    apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF, rdata);
    check_mode_readback();
    apb_access(1'b1, ADDR_MODE, 32'hFFFF_FFFF, rdata);
    check_mode_readback();
    apb_access(1'b1, ADDR_UNUSED, 32'h0, rdata);
    check_mode_readback();
    apb_access(1'b1, ADDR_MODE, 32'hFFFF_FFFE, rdata);
    check_mode_readback();
  endtask

  task automatic test_greater_directed();
    wait_idle();
    program_mode(MODE_GREATER);
    send_sample(5, 1'b0);
    send_sample(3, 1'b0);
    send_sample(3, 1'b0);       // equal value stays pending
    send_sample(7, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(0, 1'b1);
    send_sample(-1, 1'b1);      // one-element sequence
  endtask

  task automatic test_smaller_directed();
    wait_idle();
    program_mode(MODE_SMALLER);
    send_sample(-5, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(0, 1'b1);
    send_sample(1, 1'b1);
  endtask

  // monotonic runs past the stack depth, last one also evicts on end of sequence
  task automatic test_overflow();
    logic signed [VALUE_W-1:0] v;
    for (int m = 0; m < 2; m++) begin
      wait_idle();
      program_mode(logic'(m));
      v = 0;
      for (int k = 0; k <= STACK_DEPTH_DEF + 2; k++) begin
        if (m == MODE_GREATER) v = v - $urandom_range(1, 100);
        else v = v + $urandom_range(1, 100);
        send_sample(v, k == STACK_DEPTH_DEF + 2);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    program_mode(MODE_GREATER);
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) begin
      send_sample($signed($urandom_range(0, 8)) - 4, k == 23);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] next_sample(int style,
                                                           logic signed [VALUE_W-1:0] prev);
    case (style)
      0: begin
        return $urandom;
      end
      1: begin
        return $signed($urandom_range(0, 6)) - 3;
      end
      2: begin
        // run that keeps the stack growing under the current mode
        if (cur_mode == MODE_GREATER) return prev - $urandom_range(1, 1000);
        return prev + $urandom_range(1, 1000);
      end
      default: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // last phase runs with neither side idling
  task automatic test_random_sequences();
    int                        sent;
    int                        len;
    int                        style;
    bit                        noise;
    bit                        long_run;
    logic signed [VALUE_W-1:0] v;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      if (phase < 2) program_mode(logic'(phase));
      else program_mode(logic'($urandom_range(1)));
      no_idle = (phase == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        noise    = $urandom_range(99) < 20;
        long_run = !noise && $urandom_range(99) < 15;
        if (noise) len = $urandom_range(1, 10);
        else if (long_run) len = $urandom_range(30, 40);
        else len = $urandom_range(1, 12);
        style = long_run ? 2 : $urandom_range(3);
        v = $urandom;
        for (int k = 0; k < len; k++) begin
          v = next_sample(style, v);
          send_sample(v, noise ? ($urandom_range(3) == 0) : (k == len - 1));
        end
        sent += len;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_register_access();
    test_greater_directed();
    test_smaller_directed();
    test_overflow();
    test_backpressure();
    test_random_sequences();
    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
design/msne_pkg.sv
design/msne_queue.sv
design/msne_front.sv
design/msne_back.sv
design/monotonic_stack_next_element.sv
design/msne_checker.sv
tb/sv/tb_monotonic_stack_next_element.sv
